// ----- rtl/pbd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared types and constants of the power burst detector: request payloads,
// register map and capture limits.
// ----------------------------------------------------------------------------
package pbd_pkg;

  // Capture limits
  localparam int unsigned CAPTURE_DEPTH = 1048576;
  localparam int unsigned MAX_BURSTS    = 64;

  // Derived state widths
  localparam int SIDX_W = $clog2(CAPTURE_DEPTH + 1);  // index, may reach the depth
  localparam int CNT_W  = $clog2(MAX_BURSTS + 1);     // report count, may reach the limit

  // Field widths
  localparam int SMP_W    = 16;
  localparam int IDX_W    = 20;
  localparam int NUM_W    = 6;
  localparam int ACC_W    = 52;
  localparam int PWR_W    = 32;
  localparam int THR_W    = 32;
  localparam int MINLEN_W = 21;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register index, taken from paddr above the byte offset
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_MIN_LEN   = 1'b1;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_i;
    logic signed [SMP_W-1:0] sample_q;
    logic                    last_sample;
  } in_item_t;

  typedef struct packed {
    logic [NUM_W-1:0] burst_number;
    logic [IDX_W-1:0] start_index;
    logic [IDX_W-1:0] end_index;
    logic [IDX_W-1:0] burst_length;
    logic [ACC_W-1:0] power_sum;
  } out_item_t;

  typedef struct packed {
    logic [PWR_W-1:0] power;
    logic             last_sample;
  } pwr_item_t;

  typedef struct packed {
    logic [THR_W-1:0]    power_threshold;
    logic [MINLEN_W-1:0] min_length;
  } cfg_t;

endpackage

// ----- rtl/pbd_power.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_power
// Input register and power stage: registers each sample, forms I*I + Q*Q and
// holds the power for the burst tracker.
// ----------------------------------------------------------------------------
module pbd_power (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  pbd_pkg::in_item_t in_data,
  output logic              in_stall,
  output logic              pwr_valid,
  output pbd_pkg::pwr_item_t pwr_data,
  input  logic              pwr_take
);

  logic               smp_valid_r;
  pbd_pkg::in_item_t  smp_data_r;
  logic               pwr_valid_r;
  pbd_pkg::pwr_item_t pwr_data_r;
  pbd_pkg::pwr_item_t pwr_data_nxt;

  logic signed [pbd_pkg::PWR_W-1:0] sq_i;
  logic signed [pbd_pkg::PWR_W-1:0] sq_q;

  logic pwr_free;
  logic smp_go;
  logic smp_free;

  assign pwr_free = !pwr_valid_r || pwr_take;
  assign smp_go   = smp_valid_r && pwr_free;
  assign smp_free = !smp_valid_r || smp_go;
  assign in_stall = !smp_free;

  // Each square is at most 2^30, so the sum fits unsigned 32 bits
  assign sq_i = smp_data_r.sample_i * smp_data_r.sample_i;
  assign sq_q = smp_data_r.sample_q * smp_data_r.sample_q;

  always_comb begin
    pwr_data_nxt.power       = unsigned'(sq_i) + unsigned'(sq_q);
    pwr_data_nxt.last_sample = smp_data_r.last_sample;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
      pwr_valid_r <= 1'b0;
    end else begin
      if (smp_free) begin
        smp_valid_r <= in_valid;
      end
      if (pwr_free) begin
        pwr_valid_r <= smp_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (smp_free && in_valid) begin
      smp_data_r <= in_data;
    end
    if (smp_go) begin
      pwr_data_r <= pwr_data_nxt;
    end
  end

  assign pwr_valid = pwr_valid_r;
  assign pwr_data  = pwr_data_r;

endmodule

// ----- rtl/pbd_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_tracker
// Burst tracker: compares power with the threshold, follows burst edges,
// accumulates burst power and forms the burst record.
// ----------------------------------------------------------------------------
module pbd_tracker (
  input  logic                clk,
  input  logic                rst_n,
  input  pbd_pkg::cfg_t       cfg,
  input  logic                pwr_go,
  input  pbd_pkg::pwr_item_t  pwr_data,
  output logic                res_valid,
  output pbd_pkg::out_item_t  res_data
);

  localparam int SUM_W = pbd_pkg::ACC_W + 1;

  logic                        in_burst_r;
  logic                        in_burst_nxt;
  logic [pbd_pkg::IDX_W-1:0]   start_r;
  logic [pbd_pkg::IDX_W-1:0]   start_nxt;
  logic [pbd_pkg::SIDX_W-1:0]  idx_r;
  logic [pbd_pkg::SIDX_W-1:0]  idx_nxt;
  logic [pbd_pkg::ACC_W-1:0]   acc_r;
  logic [pbd_pkg::ACC_W-1:0]   acc_nxt;
  logic [pbd_pkg::CNT_W-1:0]   cnt_r;
  logic [pbd_pkg::CNT_W-1:0]   cnt_nxt;

  logic                        active;
  logic                        above;
  logic                        emit;
  logic [pbd_pkg::ACC_W-1:0]   acc_base;
  logic [SUM_W-1:0]            acc_sum;
  logic [pbd_pkg::SIDX_W-1:0]  len;

  assign active   = idx_r < pbd_pkg::SIDX_W'(pbd_pkg::CAPTURE_DEPTH);
  assign above    = pwr_data.power > cfg.power_threshold;
  assign acc_base = in_burst_r ? acc_r : '0;
  assign acc_sum  = {1'b0, acc_base} + SUM_W'(pwr_data.power);
  assign len      = idx_r - pbd_pkg::SIDX_W'(start_r);

  always_comb begin
    in_burst_nxt = in_burst_r;
    start_nxt    = start_r;
    idx_nxt      = idx_r;
    acc_nxt      = acc_r;
    cnt_nxt      = cnt_r;
    emit         = 1'b0;
    if (active) begin
      if (above) begin
        in_burst_nxt = 1'b1;
        if (!in_burst_r) begin
          start_nxt = idx_r[pbd_pkg::IDX_W-1:0];
        end
        // saturate the accumulator on carry out
        acc_nxt = acc_sum[pbd_pkg::ACC_W] ? '1 : acc_sum[pbd_pkg::ACC_W-1:0];
      end else if (in_burst_r) begin
        if ((len > pbd_pkg::SIDX_W'(cfg.min_length)) &&
            (cnt_r < pbd_pkg::CNT_W'(pbd_pkg::MAX_BURSTS))) begin
          emit    = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
        in_burst_nxt = 1'b0;
        acc_nxt      = '0;
      end
      idx_nxt = idx_r + 1'b1;
    end
    // close the capture: an open burst is dropped
    if (pwr_data.last_sample) begin
      in_burst_nxt = 1'b0;
      start_nxt    = '0;
      idx_nxt      = '0;
      acc_nxt      = '0;
      cnt_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_burst_r <= 1'b0;
      start_r    <= '0;
      idx_r      <= '0;
      acc_r      <= '0;
      cnt_r      <= '0;
    end else if (pwr_go) begin
      in_burst_r <= in_burst_nxt;
      start_r    <= start_nxt;
      idx_r      <= idx_nxt;
      acc_r      <= acc_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  assign res_valid = pwr_go && emit;

  always_comb begin
    res_data.burst_number = cnt_r[pbd_pkg::NUM_W-1:0];
    res_data.start_index  = start_r;
    res_data.end_index    = idx_r[pbd_pkg::IDX_W-1:0];
    res_data.burst_length = len[pbd_pkg::IDX_W-1:0];
    res_data.power_sum    = acc_r;
  end

endmodule

// ----- rtl/power_burst_detector_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_burst_detector_core
// Energy threshold burst detector over complex I/Q samples, with a register
// port for the threshold and the minimum burst length.
// ----------------------------------------------------------------------------
//   channel  ports                               carries
//   in       in_valid / in_stall / in_data       one I/Q sample and capture end
//   out      out_valid / out_stall / out_data    one burst record
//   cfg      psel penable pwrite paddr pwdata    threshold and minimum length
//
// One sample per clock unless out_stall holds the pipeline; a record is
// presented once its closing sample has passed the input register, then the
// power register, then the result register, with the tracker step and its
// 52-bit accumulate in front of the result register.
// Reset is synchronous and clears the valid flags, the configuration registers and the capture state.
// A stalled record holds the result register; out_stall backs up through the
// stages to in_stall in the same cycle, so no request is lost.
// ----------------------------------------------------------------------------
module power_burst_detector_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  pbd_pkg::in_item_t           in_data,
  output logic                        in_stall,
  output logic                        out_valid,
  output pbd_pkg::out_item_t          out_data,
  input  logic                        out_stall,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pbd_pkg::PADDR_W-1:0] paddr,
  input  logic [pbd_pkg::PDATA_W-1:0] pwdata,
  output logic [pbd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  logic [pbd_pkg::THR_W-1:0]    thr_r;
  logic [pbd_pkg::MINLEN_W-1:0] min_len_r;
  logic                         reg_sel;
  logic                         wr_en;
  pbd_pkg::cfg_t                cfg;

  logic                 pwr_valid;
  pbd_pkg::pwr_item_t   pwr_data;
  logic                 pwr_go;
  logic                 res_valid;
  pbd_pkg::out_item_t   res_data;

  logic                 out_valid_r;
  pbd_pkg::out_item_t   out_data_r;
  logic                 out_free;

  // register port
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= '0;
      min_len_r <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        pbd_pkg::REG_THRESHOLD: thr_r     <= pwdata[pbd_pkg::THR_W-1:0];
        pbd_pkg::REG_MIN_LEN:   min_len_r <= pwdata[pbd_pkg::MINLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      pbd_pkg::REG_THRESHOLD: prdata = thr_r;
      pbd_pkg::REG_MIN_LEN:   prdata = pbd_pkg::PDATA_W'(min_len_r);
      default:                prdata = '0;
    endcase
  end

  always_comb begin
    cfg.power_threshold = thr_r;
    cfg.min_length      = min_len_r;
  end

  // datapath
  assign out_free = !out_valid_r || !out_stall;
  assign pwr_go   = pwr_valid && out_free;

  pbd_power u_power (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .pwr_valid (pwr_valid),
    .pwr_data  (pwr_data),
    .pwr_take  (pwr_go)
  );

  pbd_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pwr_go    (pwr_go),
    .pwr_data  (pwr_data),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_len_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.burst_length ==
                  pbd_pkg::IDX_W'(out_data.end_index - out_data.start_index))
    else $error("burst length does not match its indices");

  a_no_record_while_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> !res_valid)
    else $error("record produced while the result register is held");

  a_threshold_write: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && wr_en && reg_sel == pbd_pkg::REG_THRESHOLD |=> thr_r == $past(pwdata))
    else $error("threshold register not written");

endmodule
